// ===== rtl/core/afu_pkg.sv =====
package afu_pkg;

	localparam int DATA_W = 16;
	localparam int APB_DW = 32;
	localparam int APB_AW = 2;
	localparam logic [APB_AW-1:0] ADDR_ACT_MODE = '0;

	localparam int MAG_W = 12;
	localparam int IDX_W = 8;
	localparam int LUT_N = 1 << IDX_W;
	localparam int SIG_SPAN = 128;

	typedef logic [MAG_W-1:0] mag_t;
	typedef mag_t lut_t [LUT_N];

	localparam mag_t MAG_MAX = MAG_W'(2048);
	localparam mag_t MAG_PAD = '1;
	localparam logic signed [DATA_W-1:0] Y_ONE = DATA_W'(256);
	localparam logic signed [DATA_W-1:0] Y_HALF = DATA_W'(128);

	typedef enum logic [1:0] {
		MODE_IDENT,
		MODE_RELU,
		MODE_SIGMOID,
		MODE_TANH
	} act_mode_t;

	typedef struct packed {
		act_mode_t mode;
		logic neg;
		logic sat;
		mag_t mag;
		logic [IDX_W-1:0] cnt;
		logic signed [DATA_W-1:0] y;
	} afu_item_t;

	function automatic mag_t ceil_mag(input real r);
		return mag_t'(int'($ceil(r)));
	endfunction

	// smallest |x| (Q8.8 code) at which round(256*tanh) reaches i+1
	function automatic mag_t tanh_thr(input int i);
		return ceil_mag(128.0 * ($ln(513.0 + 2.0 * i) - $ln(511.0 - 2.0 * i)));
	endfunction

	// smallest x >= 0 at which round(256*sigmoid) reaches 129+i
	function automatic mag_t sig_thr(input int i);
		return ceil_mag(256.0 * ($ln(128.5 + i) - $ln(127.5 - i)));
	endfunction

	function automatic lut_t sig_lut();
		lut_t t;
		for (int i = 0; i < LUT_N; i++) begin
			t[i] = (i < SIG_SPAN) ? sig_thr(i) : MAG_PAD;
		end
		return t;
	endfunction

	function automatic lut_t tanh_lut();
		lut_t t;
		for (int i = 0; i < LUT_N; i++) begin
			t[i] = (i < LUT_N - 1) ? tanh_thr(i) : MAG_PAD;
		end
		return t;
	endfunction

	localparam lut_t SIG_LUT = sig_lut();
	localparam lut_t TANH_LUT = tanh_lut();
	localparam mag_t TANH_TOP = tanh_thr(LUT_N - 1);

endpackage

// ===== rtl/core/afu_stream_if.sv =====
interface afu_in_if;
	import afu_pkg::*;

	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] x;

	modport source (output valid, output x, input ready);
	modport sink (input valid, input x, output ready);
endinterface

interface afu_out_if;
	import afu_pkg::*;

	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] y;

	modport source (output valid, output y, input ready);
	modport sink (input valid, input y, output ready);
endinterface

// ===== rtl/core/afu_cfg.sv =====
module afu_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [afu_pkg::APB_AW-1:0] paddr,
	input  logic [afu_pkg::APB_DW-1:0] pwdata,
	output logic [afu_pkg::APB_DW-1:0] prdata,
	output logic pready,
	output afu_pkg::act_mode_t act_mode
);
	import afu_pkg::*;

	act_mode_t act_mode_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite && (paddr == ADDR_ACT_MODE);
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ACT_MODE) ? APB_DW'(act_mode_q) : '0;
	assign act_mode = act_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q <= MODE_IDENT;
		end else if (wr_en) begin
			act_mode_q <= act_mode_t'(pwdata[1:0]);
		end
	end

endmodule

// ===== rtl/core/afu_front.sv =====
module afu_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [afu_pkg::DATA_W-1:0] x,
	input  afu_pkg::act_mode_t mode,
	output logic out_valid,
	input  logic out_ready,
	output afu_pkg::afu_item_t item
);
	import afu_pkg::*;

	localparam logic [DATA_W:0] MagCap = (DATA_W + 1)'(MAG_MAX);

	logic vld_s1;
	afu_item_t item_s1;
	afu_item_t item_d;
	logic [DATA_W:0] mag_full;

	assign in_ready = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign item = item_s1;

	always_comb begin
		mag_full = x[DATA_W-1] ? -{x[DATA_W-1], x} : {x[DATA_W-1], x};
		item_d.mode = mode;
		item_d.neg = x[DATA_W-1];
		item_d.mag = (mag_full > MagCap) ? MAG_MAX : mag_full[MAG_W-1:0];
		item_d.sat = (mode == MODE_TANH) && (item_d.mag >= TANH_TOP);
		item_d.cnt = '0;
		case (mode)
			MODE_IDENT: begin
				item_d.y = x;
			end
			MODE_RELU: begin
				item_d.y = x[DATA_W-1] ? '0 : x;
			end
			default: begin
				item_d.y = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== rtl/core/afu_search.sv =====
module afu_search (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  afu_pkg::afu_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output afu_pkg::afu_item_t out_item
);
	import afu_pkg::*;

	logic vld_sn [IDX_W];
	afu_item_t item_sn [IDX_W];
	logic vld_in [IDX_W];
	afu_item_t item_in [IDX_W];
	logic take [IDX_W];

	// one bit of the threshold count per stage, MSB first
	for (genvar g = 0; g < IDX_W; g++) begin : g_step
		localparam int Bit = IDX_W - 1 - g;
		localparam logic [IDX_W-1:0] StepBit = IDX_W'(1 << Bit);
		localparam logic [IDX_W-1:0] LowMask = IDX_W'((1 << Bit) - 1);

		logic [IDX_W-1:0] probe;
		mag_t thr;
		afu_item_t nxt;

		if (g == 0) begin : g_head
			assign vld_in[g] = in_valid;
			assign item_in[g] = in_item;
		end else begin : g_link
			assign vld_in[g] = vld_sn[g-1];
			assign item_in[g] = item_sn[g-1];
		end

		if (g == IDX_W - 1) begin : g_tail
			assign take[g] = !vld_sn[g] || out_ready;
		end else begin : g_mid
			assign take[g] = !vld_sn[g] || take[g+1];
		end

		always_comb begin
			probe = item_in[g].cnt | LowMask;
			thr = (item_in[g].mode == MODE_TANH) ? TANH_LUT[probe] : SIG_LUT[probe];
			nxt = item_in[g];
			if (thr <= item_in[g].mag) begin
				nxt.cnt = item_in[g].cnt | StepBit;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[g] <= 1'b0;
			end else if (take[g]) begin
				vld_sn[g] <= vld_in[g];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_in[g] && take[g]) begin
				item_sn[g] <= nxt;
			end
		end
	end

	assign in_ready = take[0];
	assign out_valid = vld_sn[IDX_W-1];
	assign out_item = item_sn[IDX_W-1];

endmodule

// ===== rtl/core/afu_back.sv =====
module afu_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  afu_pkg::afu_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [afu_pkg::DATA_W-1:0] y
);
	import afu_pkg::*;

	logic vld_s10;
	logic signed [DATA_W-1:0] y_s10;
	logic signed [DATA_W-1:0] cnt_x;
	logic signed [DATA_W-1:0] mag_y;
	logic signed [DATA_W-1:0] y_d;

	assign in_ready = !vld_s10 || out_ready;
	assign out_valid = vld_s10;
	assign y = y_s10;

	always_comb begin
		cnt_x = signed'(DATA_W'(in_item.cnt));
		mag_y = in_item.sat ? Y_ONE : cnt_x;
		case (in_item.mode)
			MODE_SIGMOID: begin
				y_d = in_item.neg ? Y_HALF - cnt_x : Y_HALF + cnt_x;
			end
			MODE_TANH: begin
				y_d = in_item.neg ? -mag_y : mag_y;
			end
			default: begin
				y_d = in_item.y;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (in_ready) begin
			vld_s10 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			y_s10 <= y_d;
		end
	end

endmodule

// ===== rtl/core/activation_function_unit.sv =====
// Element-wise activation unit, signed Q8.8 in and out.
// Request channel act_in carries x, result channel act_out carries y;
// both are valid/ready, a transfer happens when valid and ready are high.
// act_mode (APB, byte address 0): identity, ReLU, sigmoid or tanh.
// Write act_mode only while no request is in flight.
// Sigmoid and tanh are exact round-to-nearest values: |x| is compared
// against per-mode threshold tables by an 8-step binary search.
// Ten register stages: magnitude/clamp, eight search steps, final sign/offset.
// Throughput: one request per cycle, sustained while act_out stays ready.
// Each stage holds its item while the next one is full and stalled, so a
// stall on act_out fills the pipe bubble by bubble before act_in.ready drops;
// nothing is dropped or repeated.
// Reset (arst_n low) empties the pipe and sets act_mode to identity.
module activation_function_unit (
	input  logic clk,
	input  logic arst_n,
	afu_in_if.sink act_in,
	afu_out_if.source act_out,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [afu_pkg::APB_AW-1:0] paddr,
	input  logic [afu_pkg::APB_DW-1:0] pwdata,
	output logic [afu_pkg::APB_DW-1:0] prdata,
	output logic pready
);
	import afu_pkg::*;

	act_mode_t act_mode;
	logic front_vld;
	logic front_rdy;
	afu_item_t front_item;
	logic srch_vld;
	logic srch_rdy;
	afu_item_t srch_item;

	afu_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.act_mode (act_mode)
	);

	afu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (act_in.valid),
		.in_ready  (act_in.ready),
		.x         (act_in.x),
		.mode      (act_mode),
		.out_valid (front_vld),
		.out_ready (front_rdy),
		.item      (front_item)
	);

	afu_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_vld),
		.in_ready  (front_rdy),
		.in_item   (front_item),
		.out_valid (srch_vld),
		.out_ready (srch_rdy),
		.out_item  (srch_item)
	);

	afu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (srch_vld),
		.in_ready  (srch_rdy),
		.in_item   (srch_item),
		.out_valid (act_out.valid),
		.out_ready (act_out.ready),
		.y         (act_out.y)
	);

endmodule

// ===== test/afu_checker.sv =====
`timescale 1ns / 100ps

module afu_checker (
	input  logic clk,
	input  logic arst_n,
	afu_in_if in_mon,
	afu_out_if out_mon,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [afu_pkg::APB_AW-1:0] paddr,
	input  logic [afu_pkg::APB_DW-1:0] pwdata,
	input  logic [afu_pkg::APB_DW-1:0] prdata,
	input  logic pready,
	output int fails,
	output int pending
);
	import afu_pkg::*;

	localparam logic [63:0] Q62_ONE = 64'd1 << 62;

	act_mode_t mode;
	logic signed [DATA_W-1:0] y_due [$];

	assign pending = y_due.size();

	task automatic report(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		fails++;
	endtask

	// truncated (a * b) >> 62, operands in Q2.62
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// e^(-n/256) in Q2.62
	function automatic logic [63:0] exp_neg_q62(input int unsigned n);
		logic [63:0] term, sum, base, acc;
		int unsigned k;
		term = Q62_ONE;
		sum = Q62_ONE;
		acc = Q62_ONE;
		for (int i = 1; i <= 10; i++) begin
			term = term / (64'd256 * 64'(i));
			if (i % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		base = sum;
		k = n & 32'd4095;
		while (k != 0) begin
			if (k[0]) begin
				acc = q62_mul(acc, base);
			end
			base = q62_mul(base, base);
			k = k >> 1;
		end
		return acc;
	endfunction

	// round(256 * num / den)
	function automatic int ratio_q88(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] n, d, q;
		n = num >> 10;
		d = den >> 10;
		if (d == 0) begin
			return 0;
		end
		q = (64'd512 * n) / d;
		return int'((q + 64'd1) >> 1);
	endfunction

	function automatic int sigmoid_q88(input int xv);
		int unsigned mag;
		logic [63:0] e;
		mag = (xv < 0) ? -xv : xv;
		if (mag > 2048) begin
			mag = 2048;
		end
		e = exp_neg_q62(mag);
		if (xv >= 0) begin
			return ratio_q88(Q62_ONE, Q62_ONE + e);
		end
		return ratio_q88(e, Q62_ONE + e);
	endfunction

	function automatic int tanh_q88(input int xv);
		int unsigned mag;
		logic [63:0] e;
		int r;
		mag = (xv < 0) ? -xv : xv;
		if (mag > 1024) begin
			mag = 1024;
		end
		e = exp_neg_q62(2 * mag);
		r = ratio_q88(Q62_ONE - e, Q62_ONE + e);
		return (xv < 0) ? -r : r;
	endfunction

	function automatic logic signed [DATA_W-1:0] activate(input act_mode_t m,
			input logic signed [DATA_W-1:0] x);
		int xv, yv;
		xv = x;
		case (m)
			MODE_IDENT: yv = xv;
			MODE_RELU: yv = (xv > 0) ? xv : 0;
			MODE_SIGMOID: yv = sigmoid_q88(xv);
			default: yv = tanh_q88(xv);
		endcase
		if (yv > 32767) begin
			yv = 32767;
		end
		if (yv < -32768) begin
			yv = -32768;
		end
		return DATA_W'(yv);
	endfunction

	initial begin
		fails = 0;
		mode = MODE_IDENT;
	end

	always @(posedge clk or negedge arst_n) begin
		logic signed [DATA_W-1:0] want;
		if (!arst_n) begin
			mode = MODE_IDENT;
			y_due.delete();
		end else begin
			if (psel && penable && pready && paddr == ADDR_ACT_MODE) begin
				if (pwrite) begin
					mode = act_mode_t'(pwdata[1:0]);
				end else if (prdata[1:0] !== mode) begin
					report($sformatf("act_mode read %0d, written %0d", prdata[1:0], mode));
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				if (y_due.size() == 0) begin
					report($sformatf("result y=%0d with no request pending", out_mon.y));
				end else begin
					want = y_due.pop_front();
					if (out_mon.y !== want) begin
						report($sformatf("y=%0d, predicted %0d", out_mon.y, want));
					end
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				y_due.push_back(activate(mode, in_mon.x));
			end
		end
	end

endmodule

// ===== test/activation_function_unit_tb.sv =====
`timescale 1ns / 100ps

module activation_function_unit_tb;
	import afu_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	int fails;
	int pending;
	int idle_cycles;
	int burst_left;

	afu_in_if in_if ();
	afu_out_if out_if ();

	activation_function_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.act_in(in_if.sink),
		.act_out(out_if.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	afu_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_if),
		.out_mon(out_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.fails(fails),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
					|| (psel && penable && pready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// result side: segments of always ready, random ready, and short stall bursts
	initial begin
		int seg_left;
		int pattern;
		int hold;
		out_if.ready = 1'b0;
		seg_left = 0;
		pattern = 0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 200);
				pattern = $urandom_range(0, 2);
			end
			seg_left--;
			case (pattern)
				0: out_if.ready = 1'b1;
				1: out_if.ready = 1'($urandom_range(0, 1));
				default: begin
					if (hold > 0) begin
						hold--;
						out_if.ready = 1'b0;
					end else if ($urandom_range(0, 9) == 0) begin
						hold = $urandom_range(1, 16);
						out_if.ready = 1'b0;
					end else begin
						out_if.ready = 1'b1;
					end
				end
			endcase
		end
	end

	task automatic send_x(input logic signed [DATA_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_if.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
		in_if.valid = 1'b1;
		in_if.x = v;
		do @(posedge clk); while (!in_if.ready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic apb_access(input logic wr, input logic [APB_DW-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = ADDR_ACT_MODE;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// drain, then write the mode with junk in the unused bits and read it back
	task automatic set_mode(input act_mode_t m);
		in_if.valid = 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		apb_access(1'b1, {30'($urandom_range(0, 32'h3fff_ffff)), 2'(m)});
		apb_access(1'b0, $urandom);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_x();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			return DATA_W'($urandom_range(0, 5120) - 2560);
		end else if (sel == 4) begin
			return DATA_W'($urandom_range(0, 400) - 200);
		end
		return DATA_W'($urandom);
	endfunction

	initial begin
		logic signed [DATA_W-1:0] corners [15];
		act_mode_t m;
		int n_items;
		corners = '{16'sh8000, -16'sd32767, -16'sd2049, -16'sd2048, -16'sd1025, -16'sd1,
			16'sd0, 16'sd1, 16'sd127, 16'sd128, 16'sd1024, 16'sd1025, 16'sd2048, 16'sd2049,
			16'sd32767};
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.x = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corners in every mode, the first pass under the reset mode
		for (int k = 0; k < 4; k++) begin
			if (k > 0) begin
				set_mode(act_mode_t'(k));
			end
			foreach (corners[i]) begin
				send_x(corners[i]);
			end
		end

		for (int ph = 0; ph < 12; ph++) begin
			m = (ph < 4) ? act_mode_t'(ph) : act_mode_t'($urandom_range(0, 3));
			set_mode(m);
			n_items = $urandom_range(80, 150);
			for (int i = 0; i < n_items; i++) begin
				send_x(pick_x());
			end
		end

		in_if.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
